// ===== hdl/atsm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the adaptive terminal sliding mode step block.
// Used by the controller, the datapath and the top level.
package atsm_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 35;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ITER_W    = 4;

    // Pi and two pi in Q16.16, rounded to nearest.
    localparam int PI_FIX     = 205887;
    localparam int TWO_PI_FIX = 411775;
    // ln 2 in Q0.30.
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    // Last iteration of the log2 squaring loop, and first and last iterations of the exp2 series.
    localparam logic [ITER_W-1:0] LOG_LAST  = 4'd15;
    localparam logic [ITER_W-1:0] EXP_FIRST = 4'd1;
    localparam logic [ITER_W-1:0] EXP_LAST  = 4'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_PERIOD  = 3'd0,
        REG_SURFACE_ALPHA  = 3'd1,
        REG_SURFACE_BETA   = 3'd2,
        REG_LINEAR_GAIN    = 3'd3,
        REG_ADAPT_RATE     = 3'd4,
        REG_GAIN_FLOOR     = 3'd5,
        REG_BOUNDARY_WIDTH = 3'd6,
        REG_ANGULAR_MODE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_NORM,
        OP_SQUARE,
        OP_LOGMUL,
        OP_TMUL,
        OP_TAYA,
        OP_TAYB,
        OP_EXP,
        OP_ALPHA,
        OP_SURF,
        OP_RATE,
        OP_INC,
        OP_DRIVE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
    } dp_cmd_t;

    typedef struct packed {
        logic diff_zero;
    } dp_stat_t;

    // ceil(2^34 / i): the exact floor quotient of a value below 2^30 by i
    // is (x * recip) >> 34 for i up to twelve.
    function automatic logic [MUL_B_W-1:0] series_recip(input logic [ITER_W-1:0] i);
        logic [MUL_B_W-1:0] r;
        case (i)
            4'd1:    r = 35'd17179869184;
            4'd2:    r = 35'd8589934592;
            4'd3:    r = 35'd5726623062;
            4'd4:    r = 35'd4294967296;
            4'd5:    r = 35'd3435973837;
            4'd6:    r = 35'd2863311531;
            4'd7:    r = 35'd2454267027;
            4'd8:    r = 35'd2147483648;
            4'd9:    r = 35'd1908874354;
            4'd10:   r = 35'd1717986919;
            4'd11:   r = 35'd1561806290;
            4'd12:   r = 35'd1431655766;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/atsm_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the sliding mode step: issues one datapath command per cycle.
// Depends on atsm_pkg for the command and status types.
module atsm_ctrl
    import atsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NORM  = 13'b0000000000010,
        S_SQ    = 13'b0000000000100,
        S_LOG   = 13'b0000000001000,
        S_TMUL  = 13'b0000000010000,
        S_TA    = 13'b0000000100000,
        S_TB    = 13'b0000001000000,
        S_EXP   = 13'b0000010000000,
        S_ALPHA = 13'b0000100000000,
        S_SURF  = 13'b0001000000000,
        S_RATE  = 13'b0010000000000,
        S_INC   = 13'b0100000000000,
        S_DRIVE = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              drive_fire;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign drive_fire = (state_reg == S_DRIVE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_IDLE;
        cmd.iter   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                cmd.op     = OP_NORM;
                cnt_next   = '0;
                state_next = stat.diff_zero ? S_ALPHA : S_SQ;
            end
            S_SQ:
            begin
                cmd.op   = OP_SQUARE;
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == LOG_LAST)
                begin
                    state_next = S_LOG;
                end
            end
            S_LOG:
            begin
                cmd.op     = OP_LOGMUL;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                cnt_next   = EXP_FIRST;
                state_next = S_TA;
            end
            S_TA:
            begin
                cmd.op     = OP_TAYA;
                state_next = S_TB;
            end
            S_TB:
            begin
                cmd.op   = OP_TAYB;
                cnt_next = cnt_reg + 4'd1;
                state_next = (cnt_reg == EXP_LAST) ? S_EXP : S_TA;
            end
            S_EXP:
            begin
                cmd.op     = OP_EXP;
                state_next = S_ALPHA;
            end
            S_ALPHA:
            begin
                cmd.op     = OP_ALPHA;
                state_next = S_SURF;
            end
            S_SURF:
            begin
                cmd.op     = OP_SURF;
                state_next = S_RATE;
            end
            S_RATE:
            begin
                cmd.op     = OP_RATE;
                state_next = S_INC;
            end
            S_INC:
            begin
                cmd.op     = OP_INC;
                state_next = S_DRIVE;
            end
            S_DRIVE:
            begin
                if (drive_fire)
                begin
                    cmd.op     = OP_DRIVE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (drive_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hdl/atsm_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the sliding mode step: configuration registers, one shared
// multiplier and the working registers. Depends on atsm_pkg.
module atsm_datapath
    import atsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic signed [31:0]   position,
    input  logic signed [31:0]   velocity,
    input  logic signed [31:0]   target_position,
    input  logic signed [31:0]   target_velocity,
    output logic signed [31:0]   drive,
    output logic signed [31:0]   surface_value,
    output logic signed [31:0]   switch_gain
);

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Difference, folded once into plus or minus pi in angular mode.
    function automatic logic signed [47:0] wrap_err(input logic signed [32:0] e,
                                                    input logic ang);
        logic [32:0]        m;
        logic signed [47:0] r;
        logic signed [47:0] v;
        m = e[32] ? (~e + 33'd1) : e;
        v = 48'(e);
        r = $signed({15'd0, m}) - 48'sd411775;
        if (ang && (m > 33'(PI_FIX)))
        begin
            v = e[32] ? -r : r;
        end
        return v;
    endfunction

    // Configuration.
    logic [16:0] ts_reg;
    logic [30:0] alpha_reg;
    logic [17:0] beta_reg;
    logic [30:0] k2_reg;
    logic [30:0] kadapt_reg;
    logic [30:0] kmin_reg;
    logic [30:0] mu_reg;
    logic        angular_reg;

    // Working registers.
    logic signed [31:0] e1_reg, e2_reg;
    logic [4:0]         exp_reg;
    logic [30:0]        mant_reg;
    logic [15:0]        frac_reg;
    logic signed [22:0] y_reg;
    logic [29:0]        t_reg;
    logic [30:0]        term_reg;
    logic [29:0]        tp_reg;
    logic [31:0]        sum_reg;
    logic [30:0]        pow_reg;
    logic [45:0]        pw_reg;
    logic signed [31:0] s_reg;
    logic               w_pos_reg, w_neg_reg;
    logic signed [31:0] rate_reg;
    logic signed [31:0] k1_reg, prev_reg;
    logic signed [31:0] drive_reg, surf_out_reg, gain_out_reg;

    // Shared multiplier.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;

    // Combinational helpers.
    logic [31:0]        e2_mag;
    logic [4:0]         lead;
    logic [4:0]         norm_sh;
    logic [31:0]        x_shift;
    logic [31:0]        sq;
    logic signed [20:0] lg;
    logic [20:0]        lg_mag;
    logic [22:0]        y_mag;
    logic [30:0]        sum_clip;
    logic signed [7:0]  exp_sh;
    logic [7:0]         rsh;
    logic [31:0]        s_mag;
    logic signed [32:0] rate_sum;
    logic [31:0]        rate_mag;
    logic [31:0]        inc_mag;
    logic signed [31:0] rate_val;
    logic signed [47:0] kw;
    logic signed [47:0] fs;

    assign stat.diff_zero = (e2_reg == 32'sd0);

    assign e2_mag   = e2_reg[31] ? (~e2_reg + 32'd1) : e2_reg;
    assign s_mag    = s_reg[31] ? (~s_reg + 32'd1) : s_reg;
    assign lg       = {~exp_reg[4], exp_reg[3:0], frac_reg};
    assign lg_mag   = lg[20] ? (~lg + 21'd1) : lg;
    assign rate_sum = {rate_reg[31], rate_reg} + {prev_reg[31], prev_reg};
    assign rate_mag = rate_sum[32] ? 32'(~rate_sum + 33'd1) : rate_sum[31:0];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (e2_mag[i])
            begin
                lead = 5'(i);
            end
        end
    end

    assign norm_sh = 5'd30 - lead;
    assign x_shift = e2_mag << norm_sh;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_SQUARE:
            begin
                mul_a = 32'(mant_reg);
                mul_b = 35'(mant_reg);
            end
            OP_LOGMUL:
            begin
                mul_a = 32'(lg_mag);
                mul_b = 35'(beta_reg);
            end
            OP_TMUL:
            begin
                mul_a = 32'(y_reg[15:0]);
                mul_b = 35'(LN2_Q30);
            end
            OP_TAYA:
            begin
                mul_a = 32'(term_reg);
                mul_b = 35'(t_reg);
            end
            OP_TAYB:
            begin
                mul_a = 32'(tp_reg);
                mul_b = series_recip(cmd.iter);
            end
            OP_ALPHA:
            begin
                mul_a = 32'(pow_reg);
                mul_b = 35'(alpha_reg);
            end
            OP_INC:
            begin
                mul_a = rate_mag;
                mul_b = 35'(ts_reg);
            end
            OP_DRIVE:
            begin
                mul_a = s_mag;
                mul_b = 35'(k2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = 67'(mul_a) * 67'(mul_b);

    assign sq       = prod[61:30];
    assign y_mag    = prod[38:16];
    assign inc_mag  = prod[48:17];
    assign sum_clip = sum_reg[31] ? 31'h7FFFFFFF : sum_reg[30:0];
    assign exp_sh   = {y_reg[22], y_reg[22:16]} - 8'sd14;
    assign rsh      = 8'(-exp_sh);

    always_comb
    begin
        if (!(($signed(k1_reg) > $signed({1'b0, kmin_reg}))))
        begin
            rate_val = $signed({1'b0, kmin_reg});
        end
        else if (s_mag > {1'b0, mu_reg})
        begin
            rate_val = $signed({1'b0, kadapt_reg});
        end
        else if (s_mag < {1'b0, mu_reg})
        begin
            rate_val = -$signed({1'b0, kadapt_reg});
        end
        else
        begin
            rate_val = 32'sd0;
        end
    end

    assign kw = 48'(k1_reg);
    assign fs = s_reg[31] ? -$signed({2'b0, prod[61:16]}) : $signed({2'b0, prod[61:16]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg      <= 17'd655;
            alpha_reg   <= 31'd65536;
            beta_reg    <= 18'd98304;
            k2_reg      <= 31'd65536;
            kadapt_reg  <= 31'd65536;
            kmin_reg    <= 31'd6554;
            mu_reg      <= 31'd655;
            angular_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_SAMPLE_PERIOD:  ts_reg      <= cfg_data[16:0];
                REG_SURFACE_ALPHA:  alpha_reg   <= cfg_data[30:0];
                REG_SURFACE_BETA:   beta_reg    <= cfg_data[17:0];
                REG_LINEAR_GAIN:    k2_reg      <= cfg_data[30:0];
                REG_ADAPT_RATE:     kadapt_reg  <= cfg_data[30:0];
                REG_GAIN_FLOOR:     kmin_reg    <= cfg_data[30:0];
                REG_BOUNDARY_WIDTH: mu_reg      <= cfg_data[30:0];
                REG_ANGULAR_MODE:   angular_reg <= cfg_data[0];
                default:            angular_reg <= angular_reg;
            endcase
        end
    end

    // Adaptive gain state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg   <= '0;
            prev_reg <= '0;
        end
        else if (cmd.op == OP_INC)
        begin
            k1_reg   <= sat48(kw + (rate_sum[32] ? -$signed({16'd0, inc_mag})
                                                 : $signed({16'd0, inc_mag})));
            prev_reg <= rate_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                e1_reg <= sat48(wrap_err({target_position[31], target_position}
                                         - {position[31], position}, angular_reg));
                e2_reg <= sat48(wrap_err({target_velocity[31], target_velocity}
                                         - {velocity[31], velocity}, angular_reg));
            end
            OP_NORM:
            begin
                exp_reg  <= lead;
                mant_reg <= (lead == 5'd31) ? e2_mag[31:1] : x_shift[30:0];
                frac_reg <= '0;
            end
            OP_SQUARE:
            begin
                mant_reg <= sq[31] ? sq[31:1] : sq[30:0];
                frac_reg <= {frac_reg[14:0], sq[31]};
            end
            OP_LOGMUL:
            begin
                y_reg <= lg[20] ? -$signed(y_mag) : $signed(y_mag);
            end
            OP_TMUL:
            begin
                t_reg    <= prod[45:16];
                term_reg <= 31'h40000000;
                sum_reg  <= 32'h40000000;
            end
            OP_TAYA:
            begin
                tp_reg <= prod[59:30];
            end
            OP_TAYB:
            begin
                term_reg <= {1'b0, prod[63:34]};
                sum_reg  <= sum_reg + {2'b0, prod[63:34]};
            end
            OP_EXP:
            begin
                if (exp_sh > 8'sd0)
                begin
                    pow_reg <= 31'h7FFFFFFF;
                end
                else if (rsh >= 8'd31)
                begin
                    pow_reg <= '0;
                end
                else
                begin
                    pow_reg <= sum_clip >> rsh[4:0];
                end
            end
            OP_ALPHA:
            begin
                pw_reg <= stat.diff_zero ? '0 : prod[61:16];
            end
            OP_SURF:
            begin
                s_reg <= sat48(48'(e1_reg) + (e2_reg[31] ? -$signed({2'b0, pw_reg})
                                                        : $signed({2'b0, pw_reg})));
            end
            OP_RATE:
            begin
                rate_reg  <= rate_val;
                w_pos_reg <= s_mag > {1'b0, mu_reg};
                w_neg_reg <= s_mag < {1'b0, mu_reg};
            end
            OP_DRIVE:
            begin
                drive_reg    <= sat48((w_pos_reg ? -kw : (w_neg_reg ? kw : 48'sd0)) - fs);
                surf_out_reg <= s_reg;
                gain_out_reg <= k1_reg;
            end
            default:
            begin
                e1_reg <= e1_reg;
            end
        endcase
    end

    assign drive         = drive_reg;
    assign surface_value = surf_out_reg;
    assign switch_gain   = gain_out_reg;

endmodule

// ===== hdl/adaptive_terminal_sliding_mode_step.sv =====
`timescale 1ns / 1ps
// Adaptive terminal sliding mode step: one control step per input item.
// Input channel: position, velocity and their set points, signed Q16.16.
// Output channel: drive u, sliding variable s and adaptive gain K1.
// Configuration channel: register index and data. It is always ready, and
// registers should be written only while the block is idle.
// A step runs the sixteen log2 squarings and the twelve exp2 series terms,
// each term a TAYA and a TAYB step, on the one shared 32 by 35 multiplier.
// When the velocity error is zero the power is skipped.
// The block takes one item at a time; the next item is accepted in the cycle
// after the result is loaded into the output register.
// Reset clears the adaptive gain and its previous rate and restores every
// configuration register to its reset value.
// If the receiver stalls, the result waits in the output register and the
// next item is still accepted and processed up to the point where its own
// result would be loaded.
// Depends on atsm_pkg, atsm_ctrl and atsm_datapath.
module adaptive_terminal_sliding_mode_step
    import atsm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   position,
    input  logic signed [31:0]   velocity,
    input  logic signed [31:0]   target_position,
    input  logic signed [31:0]   target_velocity,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   drive,
    output logic signed [31:0]   surface_value,
    output logic signed [31:0]   switch_gain,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The register file takes a write in any cycle.
    assign cfg_ready = 1'b1;

    atsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath captures the errors directly from the ports in the
    // accepting cycle, so the sender may change the payload afterwards.
    atsm_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .position        (position),
        .velocity        (velocity),
        .target_position (target_position),
        .target_velocity (target_velocity),
        .drive           (drive),
        .surface_value   (surface_value),
        .switch_gain     (switch_gain)
    );

endmodule

// ===== hdl/atsm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the sliding mode step, bound to the top level.
// Depends only on the handshake and result ports of the top level.
module atsm_checker
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic signed [31:0]   drive,
    input logic signed [31:0]   surface_value,
    input logic signed [31:0]   switch_gain
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(drive) && $stable(surface_value)
                                    && $stable(switch_gain))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted during a step");

    // A new result only appears at the end of a step.
    a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without a step in progress");

endmodule

bind adaptive_terminal_sliding_mode_step atsm_checker u_atsm_checker (.*);
